// ----- rtl/lia_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lia_pkg
// Types and constants shared by the LIFO ID allocator: request and
// response records, action and status codes, field widths.
// ----------------------------------------------------------------------------
package lia_pkg;

  localparam int ID_W    = 8;
  localparam int ID_SPAN = 256;
  localparam int CNT_W   = 9;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TEST    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USED = 2'd1,
    ST_RANGE    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    status_t           status;
    logic              in_use;
    logic [CNT_W-1:0]  issued_count;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/lifo_id_allocator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_id_allocator_top
// Hands out IDs: reuses the most recently released ID from a LIFO free
// stack, else issues a new ID at the high-water mark. Alloc, release and
// clear requests maintain a used bitmap and the stack; test reads a bit.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------
//   request  | in        | req_valid / req_ready  | req_data (req_t)
//   response | out       | rsp_valid / rsp_ready  | rsp_data (rsp_t)
//
// Each request first reads the stack top and the used bit from the RAMs,
// then updates and writes back. The RAM read is registered, so a new
// request is not accepted while the previous one is in its execute step.
// A response waits in the output register; the next request is accepted
// meanwhile and its execute step holds until the register frees up.
// Reset needs no clearing pass: a used bit below the high-water mark is
// always written at allocation before it is read.
// ----------------------------------------------------------------------------
module lifo_id_allocator_top #(
  parameter int MAX_IDS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  lia_pkg::req_t req_data,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output lia_pkg::rsp_t rsp_data
);

  import lia_pkg::*;

  localparam int PW = $clog2(MAX_IDS + 1);
  localparam int SA = $clog2(MAX_IDS);
  localparam int UW = (MAX_IDS < ID_SPAN) ? MAX_IDS : ID_SPAN;
  localparam int UA = $clog2(UW);
  localparam int CW = (PW > ID_W) ? PW : ID_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t          state;
  req_t            req_q;
  logic [PW-1:0]   hw, hw_next;
  logic [PW-1:0]   depth, depth_next;
  rsp_t            res;

  logic            accept, stall, go;
  logic [ID_W-1:0] stk_rdata;
  logic            used_rdata;
  logic            used_we, used_wdata;
  logic [UA-1:0]   used_waddr;
  logic            stk_we;
  logic [SA-1:0]   stk_waddr;
  logic            in_range;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign stall     = rsp_valid && !rsp_ready;
  assign go        = (state == S_EXEC) && !stall;
  assign in_range  = CW'(req_q.id) < CW'(hw);

  lia_ram #(.DEPTH(MAX_IDS), .WIDTH(ID_W)) u_stack (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (SA'(depth - PW'(1))),
    .rd_data (stk_rdata),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (req_q.id)
  );

  lia_ram #(.DEPTH(UW), .WIDTH(1)) u_used (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (req_data.id[UA-1:0]),
    .rd_data (used_rdata),
    .wr_en   (used_we),
    .wr_addr (used_waddr),
    .wr_data (used_wdata)
  );

  always_comb begin
    hw_next    = hw;
    depth_next = depth;
    res        = '0;
    used_we    = 1'b0;
    used_waddr = req_q.id[UA-1:0];
    used_wdata = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = depth[SA-1:0];
    case (req_q.action)
      ACT_ALLOC: begin
        if (depth != '0) begin
          // pop the most recently released ID
          depth_next    = depth - PW'(1);
          res.result_id = stk_rdata;
          used_we       = go;
          used_waddr    = stk_rdata[UA-1:0];
          used_wdata    = 1'b1;
        end else if (CW'(hw) < CW'(MAX_IDS)) begin
          hw_next       = hw + PW'(1);
          res.result_id = ID_W'(hw);
          used_we       = go && (CW'(hw) < CW'(UW));
          used_waddr    = hw[UA-1:0];
          used_wdata    = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      ACT_RELEASE: begin
        res.result_id = req_q.id;
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (!used_rdata) begin
          res.status = ST_NOT_USED;
        end else if (CW'(depth) < CW'(MAX_IDS)) begin
          used_we    = go;
          stk_we     = go;
          depth_next = depth + PW'(1);
        end
      end
      ACT_TEST: begin
        res.result_id = req_q.id;
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          res.in_use = used_rdata;
        end
      end
      default: begin
        hw_next    = '0;
        depth_next = '0;
      end
    endcase
    res.issued_count = CNT_W'(hw_next);
    res.free_count   = CNT_W'(depth_next);
    res.used_count   = CNT_W'(hw_next - depth_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      hw        <= '0;
      depth     <= '0;
    end else begin
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_q <= req_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold until the output register can take the response
          if (!stall) begin
            rsp_data  <= res;
            hw        <= hw_next;
            depth     <= depth_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_depth_le_hw: assert property (@(posedge clk) disable iff (rst)
    depth <= hw)
    else $error("free stack deeper than issued IDs");

  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status == ST_FULL) |->
      (rsp_data.free_count == '0 && rsp_data.in_use == 1'b0))
    else $error("full response with free IDs on the stack");

  a_in_use_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.in_use) |-> (rsp_data.status == ST_OK))
    else $error("in_use set on a failed request");

  a_exec_issue: assert property (@(posedge clk) disable iff (rst)
    (go && req_q.action == ACT_CLEAR) |=> (hw == '0 && depth == '0))
    else $error("clear did not empty the allocator");

endmodule
`default_nettype wire

// ----- rtl/lia_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lia_ram
// Single-clock RAM, one write port and one read port with registered
// read data. Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module lia_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
